// ===== design/tco_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tco_pkg: shared types and constants for the three-caster odometry block
// Register indexes, CORDIC constants and the sequencer state type.
// ----------------------------------------------------------------------------
package tco_pkg;

	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned CFG_W     = 24;

	localparam logic [REG_IDX_W-1:0] REG_MPT   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_FLG   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_FRG   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RG    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SPACE = 3'd4;

	// datapath width for CORDIC and positions
	localparam int unsigned DW = 64;

	localparam logic signed [DW-1:0] KGAIN_Q30  = 64'sd652032874;
	localparam logic signed [DW-1:0] HALFPI_Q30 = 64'sd1686629713;
	localparam logic signed [DW-1:0] PI_Q30     = 64'sd3373259426;
	localparam logic [31:0]          SQRT3_Q30  = 32'd1859775393;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIST,   // serial multiply ticks*mpt*gain
		ST_SCPREP,
		ST_SC,     // serial multiply d*sqrt3, then divide by 6<<26
		ST_SCDIV,
		ST_ROT,    // CORDIC sin/cos iterations
		ST_PX,     // serial multiply co*dist
		ST_PY,     // serial multiply si*dist
		ST_NEXT,
		ST_SUM,
		ST_DIV48,
		ST_NORM,
		ST_VEC,
		ST_DONE,
		ST_OUT
	} tco_state_t;

	function automatic logic signed [DW-1:0] atan_entry(input logic [4:0] i);
		logic signed [DW-1:0] r;
		case (i)
			5'd0:  r = 64'sd843314857;
			5'd1:  r = 64'sd497837829;
			5'd2:  r = 64'sd263043837;
			5'd3:  r = 64'sd133525159;
			5'd4:  r = 64'sd67021687;
			5'd5:  r = 64'sd33543516;
			5'd6:  r = 64'sd16775851;
			5'd7:  r = 64'sd8388437;
			5'd8:  r = 64'sd4194283;
			5'd9:  r = 64'sd2097149;
			5'd31: r = '0;
			default: r = 64'sd1 <<< (5'd30 - i);
		endcase
		return r;
	endfunction

endpackage

// ===== design/tco_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tco_in_if / tco_out_if: valid/ready channels of the odometry block
// Input carries one frame of caster readings, output one pose and step.
// ----------------------------------------------------------------------------
interface tco_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] front_left_steer;
	logic signed [15:0] front_left_ticks;
	logic signed [15:0] front_right_steer;
	logic signed [15:0] front_right_ticks;
	logic signed [15:0] rear_steer;
	logic signed [15:0] rear_ticks;
	modport source (output valid, front_left_steer, front_left_ticks, front_right_steer,
		front_right_ticks, rear_steer, rear_ticks, input ready);
	modport sink (input valid, front_left_steer, front_left_ticks, front_right_steer,
		front_right_ticks, rear_steer, rear_ticks, output ready);
endinterface

interface tco_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pose_x;
	logic signed [31:0] pose_y;
	logic signed [31:0] pose_heading;
	logic signed [31:0] step_x;
	logic signed [31:0] step_y;
	logic signed [31:0] step_turn;
	modport source (output valid, pose_x, pose_y, pose_heading, step_x, step_y,
		step_turn, input ready);
	modport sink (input valid, pose_x, pose_y, pose_heading, step_x, step_y,
		step_turn, output ready);
endinterface

// ===== design/three_caster_odometry_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_caster_odometry_unit: wheel odometry for a three-caster base
// Frame of steer/tick readings in, accumulated pose and body step out.
// ----------------------------------------------------------------------------
// Usage:
//   in  (valid/ready): one frame of three casters (steer, tick delta each).
//   out (valid/ready): pose_x/y/heading and step_x/y/turn, one item per frame.
//   cfg: wr_en/wr_idx/wr_data write the five geometry and scale registers.
// One item is processed at a time. The work per frame is thirteen bit-serial
// products, three CORDIC rotations and one vectoring pass of CORDIC_STEPS
// iterations each, up to 40 normalizing shifts, and three serial divides
// (mounting geometry and the two centroid terms). The next frame is accepted
// once the previous one has been loaded into the output register.
// If the receiver stalls, the output holds and a finished item waits in
// ST_OUT; no new frame is taken until the output register frees.
// Reset returns the configuration registers to their defaults and clears the pose.
// ----------------------------------------------------------------------------
module three_caster_odometry_unit
	import tco_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  logic [REG_IDX_W-1:0] wr_idx,
	input  logic [CFG_W-1:0]     wr_data,
	tco_in_if.sink               in,
	tco_out_if.source            out
);
	localparam int IW = $clog2(CORDIC_STEPS + 1);

	logic [23:0] mpt_q;
	logic [15:0] gfl_q, gfr_q, grr_q;
	logic [16:0] space_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpt_q   <= 24'd27012;
			gfl_q   <= 16'd4211;
			gfr_q   <= 16'd4211;
			grr_q   <= 16'd4710;
			space_q <= 17'd29950;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_MPT:   mpt_q   <= wr_data;
				REG_FLG:   gfl_q   <= wr_data[15:0];
				REG_FRG:   gfr_q   <= wr_data[15:0];
				REG_RG:    grr_q   <= wr_data[15:0];
				REG_SPACE: space_q <= wr_data[16:0];
				default: ;
			endcase
		end
	end

	tco_state_t st_q, st_d;

	logic signed [15:0] steer_q [3];
	logic signed [15:0] ticks_q [3];
	logic [1:0]  cidx_q;
	logic        mstep_q;
	logic signed [DW-1:0] x_q, y_q, z_q, dist_q, si_q;
	logic signed [DW-1:0] px_q [3];
	logic signed [DW-1:0] py_q [3];
	logic signed [DW-1:0] sc_q;
	logic [1:0]  quad_q;
	logic [IW-1:0] it_q;
	logic signed [DW-1:0] sx_q, sy_q;
	logic        dsel_q;
	// divider: restoring, one quotient bit per cycle
	logic [DW-1:0] num_q, den_q, rem_q;
	logic [6:0]    dcnt_q;
	logic          neg_q;
	logic signed [31:0] acc_x_q, acc_y_q, acc_h_q, stx_q, sty_q, stt_q;
	logic        ovalid_q;

	logic                 mstart;
	logic signed [DW-1:0] ma, mb, mp;
	logic                 mdone;

	tco_sermul u_mul (.clk, .arst_n, .start(mstart), .a(ma), .b(mb), .done(mdone), .p(mp));

	function automatic logic signed [DW-1:0] asr(input logic signed [DW-1:0] v,
		input logic [IW-1:0] n);
		return v >>> n;
	endfunction

	function automatic logic signed [DW-1:0] rnd(input logic signed [DW-1:0] v,
		input int n);
		logic signed [DW-1:0] one;
		one = 64'sd1;
		return (v + (one <<< (n - 1))) >>> n;
	endfunction

	function automatic logic signed [31:0] sat(input logic signed [DW-1:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	logic [15:0] gain_sel;
	logic signed [DW-1:0] bx_sel, by_sel, half;
	logic [13:0] p14;
	logic [DW-1:0] ax_abs, ay_abs, mag;
	logic [DW-1:0] rem_sh;
	logic signed [DW-1:0] ty;
	logic signed [DW-1:0] co_sel;
	logic signed [31:0] stx_d, sty_d, stt_d;

	always_comb begin
		case (cidx_q)
			2'd0:    gain_sel = gfl_q;
			2'd1:    gain_sel = gfr_q;
			default: gain_sel = grr_q;
		endcase
		half = DW'({space_q, 3'b000});
		case (cidx_q)
			2'd0:    begin bx_sel = sc_q;        by_sel = -half; end
			2'd1:    begin bx_sel = sc_q;        by_sel = half;  end
			default: begin bx_sel = -(sc_q <<< 1); by_sel = '0;    end
		endcase
		// cosine of the finished rotation, folded by quadrant
		case (quad_q)
			2'd0:    co_sel = x_q;
			2'd1:    co_sel = -y_q;
			2'd2:    co_sel = -x_q;
			default: co_sel = y_q;
		endcase
		p14    = steer_q[cidx_q][13:0];
		ax_abs = x_q[DW-1] ? -x_q : x_q;
		ay_abs = y_q[DW-1] ? -y_q : y_q;
		mag    = (ax_abs > ay_abs) ? ax_abs : ay_abs;
		rem_sh = {rem_q[DW-2:0], num_q[DW-1]};
		ty     = '0;
		stx_d  = sat(sx_q);
		sty_d  = sat(sy_q);
		stt_d  = 32'(-rnd(z_q, 14));
	end

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE:   if (in.valid) st_d = ST_SCPREP;
			ST_SCPREP: st_d = ST_SC;
			ST_SC:     if (mdone) st_d = ST_SCDIV;
			ST_SCDIV:  if (dcnt_q == 7'd0) st_d = ST_DIST;
			ST_DIST:   if (mdone && mstep_q) st_d = ST_ROT;
			ST_ROT:    if (it_q == IW'(CORDIC_STEPS)) st_d = ST_PX;
			ST_PX:     if (mdone) st_d = ST_PY;
			ST_PY:     if (mdone) st_d = ST_NEXT;
			ST_NEXT:   st_d = (cidx_q == 2'd2) ? ST_SUM : ST_DIST;
			ST_SUM:    st_d = ST_DIV48;
			ST_DIV48:  if (dcnt_q == 7'd0 && dsel_q) st_d = ST_VEC;
			ST_VEC:    st_d = ST_NORM;
			ST_NORM:   if (mag == '0 || mag >= (64'd1 << 40)) st_d = ST_DONE;
			ST_DONE:   if (it_q == IW'(CORDIC_STEPS)) st_d = ST_OUT;
			ST_OUT:    if (!ovalid_q || out.ready) st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		mstart = 1'b0;
		ma     = '0;
		mb     = '0;
		unique case (st_q)
			ST_SCPREP: begin
				mstart = 1'b1; ma = DW'(space_q); mb = DW'(SQRT3_Q30);
			end
			ST_NEXT: begin
				if (cidx_q != 2'd2) begin
					mstart = 1'b1; ma = DW'(ticks_q[cidx_q + 2'd1]); mb = DW'(mpt_q);
				end
			end
			ST_SCDIV: begin
				if (dcnt_q == 7'd0) begin
					mstart = 1'b1; ma = DW'(ticks_q[0]); mb = DW'(mpt_q);
				end
			end
			ST_ROT: begin
				if (it_q == IW'(CORDIC_STEPS)) begin
					mstart = 1'b1; ma = rnd(co_sel, 10); mb = dist_q;
				end
			end
			ST_PX: begin
				if (mdone) begin
					mstart = 1'b1; ma = rnd(si_q, 10); mb = dist_q;
				end
			end
			ST_DIST: begin
				if (mdone && !mstep_q) begin
					mstart = 1'b1; ma = mp; mb = DW'(gain_sel);
				end
			end
			default: ;
		endcase
	end

	assign in.ready = (st_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			acc_x_q  <= '0;
			acc_y_q  <= '0;
			acc_h_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_OUT && (!ovalid_q || out.ready)) begin
				acc_x_q  <= sat(64'(acc_x_q) + 64'(stx_d));
				acc_y_q  <= sat(64'(acc_y_q) + 64'(sty_d));
				acc_h_q  <= sat(64'(acc_h_q) + 64'(stt_d));
				ovalid_q <= 1'b1;
			end else if (ovalid_q && out.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				steer_q[0] <= in.front_left_steer;  ticks_q[0] <= in.front_left_ticks;
				steer_q[1] <= in.front_right_steer; ticks_q[1] <= in.front_right_ticks;
				steer_q[2] <= in.rear_steer;        ticks_q[2] <= in.rear_ticks;
				cidx_q     <= 2'd0;
				mstep_q    <= 1'b0;
			end
			ST_SC: begin
				if (mdone) begin
					num_q  <= mp + (64'd3 << 26);
					den_q  <= 64'd6 << 26;
					rem_q  <= '0;
					dcnt_q <= 7'd64;
				end
			end
			ST_SCDIV, ST_DIV48: begin
				if (dcnt_q != 7'd0) begin
					if (rem_sh >= den_q) begin
						rem_q <= rem_sh - den_q;
						num_q <= {num_q[DW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						num_q <= {num_q[DW-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q - 7'd1;
				end else if (st_q == ST_SCDIV) begin
					sc_q <= num_q;
				end else if (!dsel_q) begin
					// x done; floor for negative: -((|v|+47)/48)
					sx_q   <= neg_q ? -(num_q + (rem_q != '0)) : num_q;
					dsel_q <= 1'b1;
					begin : ydiv
						logic signed [DW-1:0] v;
						v = -(py_q[0] + py_q[1] + py_q[2]) + 64'sd24;
						neg_q  <= v[DW-1];
						num_q  <= v[DW-1] ? -v : v;
					end
					rem_q  <= '0;
					dcnt_q <= 7'd64;
				end else begin
					sy_q <= neg_q ? -(num_q + (rem_q != '0)) : num_q;
				end
			end
			ST_DIST: begin
				if (mdone) begin
					if (!mstep_q) mstep_q <= 1'b1;
					else begin
						mstep_q <= 1'b0;
						dist_q  <= rnd(mp, 16);
						x_q     <= KGAIN_Q30;
						y_q     <= '0;
						z_q     <= (64'(p14[11:0]) * HALFPI_Q30) >>> 12;
						quad_q  <= p14[13:12];
						it_q    <= '0;
					end
				end
			end
			ST_ROT: begin
				if (it_q != IW'(CORDIC_STEPS)) begin
					if (!z_q[DW-1]) begin
						x_q <= x_q - asr(y_q, it_q);
						y_q <= y_q + asr(x_q, it_q);
						z_q <= z_q - atan_entry(5'(it_q));
					end else begin
						x_q <= x_q + asr(y_q, it_q);
						y_q <= y_q - asr(x_q, it_q);
						z_q <= z_q + atan_entry(5'(it_q));
					end
					it_q <= it_q + 1'b1;
				end else begin
					case (quad_q)
						2'd0:    si_q <= y_q;
						2'd1:    si_q <= x_q;
						2'd2:    si_q <= -y_q;
						default: si_q <= -x_q;
					endcase
				end
			end
			ST_PX: if (mdone) px_q[cidx_q] <= bx_sel + rnd(mp, 20);
			ST_PY: if (mdone) py_q[cidx_q] <= by_sel + rnd(mp, 20);
			ST_NEXT: begin
				cidx_q  <= cidx_q + 2'd1;
				mstep_q <= 1'b0;
			end
			ST_SUM: begin : xdiv
				logic signed [DW-1:0] v;
				v = px_q[0] + px_q[1] + px_q[2] + 64'sd24;
				neg_q  <= v[DW-1];
				num_q  <= v[DW-1] ? -v : v;
				den_q  <= 64'd48;
				rem_q  <= '0;
				dcnt_q <= 7'd64;
				dsel_q <= 1'b0;
			end
			ST_VEC: begin
				x_q <= px_q[0] + px_q[1] - (px_q[2] <<< 1);
				y_q <= py_q[0] + py_q[1] - (py_q[2] <<< 1) + ty;
				z_q <= '0;
				it_q <= '0;
			end
			ST_NORM: begin
				if (mag != '0 && mag < (64'd1 << 40)) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end else if (mag != '0 && x_q[DW-1]) begin
					z_q <= y_q[DW-1] ? -PI_Q30 : PI_Q30;
					x_q <= -x_q;
					y_q <= -y_q;
				end else if (mag == '0) begin
					it_q <= IW'(CORDIC_STEPS);
				end
			end
			ST_DONE: begin
				if (it_q != IW'(CORDIC_STEPS)) begin
					if (!y_q[DW-1]) begin
						x_q <= x_q + asr(y_q, it_q);
						y_q <= y_q - asr(x_q, it_q);
						z_q <= z_q + atan_entry(5'(it_q));
					end else begin
						x_q <= x_q - asr(y_q, it_q);
						y_q <= y_q + asr(x_q, it_q);
						z_q <= z_q - atan_entry(5'(it_q));
					end
					it_q <= it_q + 1'b1;
				end
			end
			// step registers change only when the output register is free
			ST_OUT: begin
				if (!ovalid_q || out.ready) begin
					stx_q <= stx_d;
					sty_q <= sty_d;
					stt_q <= stt_d;
				end
			end
			default: ;
		endcase
	end

	assign out.valid        = ovalid_q;
	assign out.pose_x       = acc_x_q;
	assign out.pose_y       = acc_y_q;
	assign out.pose_heading = acc_h_q;
	assign out.step_x       = stx_q;
	assign out.step_y       = sty_q;
	assign out.step_turn    = stt_q;
endmodule

// ===== design/tco_sermul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tco_sermul: bit-serial signed multiplier
// Shift-and-add, one multiplier bit per cycle; multiplier taken as unsigned
// magnitude, sign applied at the end.
// ----------------------------------------------------------------------------
module tco_sermul
	import tco_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [DW-1:0] a,
	input  logic signed [DW-1:0] b,
	output logic                 done,
	output logic signed [DW-1:0] p
);
	logic [DW-1:0] mc_q;
	logic [DW-1:0] mp_q;
	logic [DW-1:0] acc_q;
	logic          neg_q;
	logic          busy_q;
	logic          done_q;
	logic [DW-1:0] abs_b;

	assign abs_b = b[DW-1] ? (~b + 1'b1) : b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && mp_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mc_q  <= a;
			mp_q  <= abs_b;
			neg_q <= b[DW-1];
			acc_q <= '0;
		end else if (busy_q && mp_q != '0) begin
			if (mp_q[0]) acc_q <= acc_q + mc_q;
			mc_q <= mc_q << 1;
			mp_q <= mp_q >> 1;
		end
	end

	assign done = done_q;
	assign p    = neg_q ? (~acc_q + 1'b1) : acc_q;
endmodule

// ===== tb/three_caster_odometry_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_caster_odometry_unit_tb: self-checking bench for caster odometry
// Drives frames of steer/tick readings with random idling on both sides,
// predicts pose and step with a bit-accurate fixed-point model, and walks
// the gain and geometry registers through several settings.
// ----------------------------------------------------------------------------
module three_caster_odometry_unit_tb;
	import tco_pkg::*;

	localparam int CORDIC_N   = 16;
	localparam int LIMIT_CYC  = 4000000;
	localparam int DRAIN_CYC  = 1000;
	localparam int N_RANDOM   = 600;
	localparam int N_DIRECTED = 18;

	// index with no register behind it
	localparam logic [REG_IDX_W-1:0] REG_NONE = 3'd7;

	typedef struct packed {
		logic signed [15:0] fl_steer;
		logic signed [15:0] fl_ticks;
		logic signed [15:0] fr_steer;
		logic signed [15:0] fr_ticks;
		logic signed [15:0] r_steer;
		logic signed [15:0] r_ticks;
	} frame_t;

	typedef struct packed {
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [31:0] pose_heading;
		logic signed [31:0] step_x;
		logic signed [31:0] step_y;
		logic signed [31:0] step_turn;
	} pose_t;

	// directed row: frame plus optional expected step (used when known)
	typedef struct {
		frame_t     fr;
		logic       has_exp;
		logic [31:0] ex_sx;
		logic [31:0] ex_sy;
		logic [31:0] ex_st;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic wr_en = 1'b0;
	logic [REG_IDX_W-1:0] wr_idx = '0;
	logic [CFG_W-1:0] wr_data = '0;

	tco_in_if  in_ch();
	tco_out_if out_ch();

	three_caster_odometry_unit #(.CORDIC_STEPS(CORDIC_N)) u_dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_idx(wr_idx),
		.wr_data(wr_data), .in(in_ch.sink), .out(out_ch.source)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	longint unsigned mpt, gain_fl, gain_fr, gain_r, spacing;
	int acc_x, acc_y, acc_hd;
	pose_t pose_q[$];
	row_t rows[N_DIRECTED];

	int errors = 0;
	int n_checked = 0;
	int n_sent = 0;
	int cycles = 0;
	int n_cfg = 0;
	bit no_idle = 0;

	function automatic longint asr(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint rnd_sh(longint v, int n);
		return (v + (64'sd1 << (n - 1))) >>> n;
	endfunction

	function automatic longint floor48(longint v);
		if (v >= 0) return v / 48;
		return -((-v + 47) / 48);
	endfunction

	function automatic int sat(longint v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return int'(v);
	endfunction

	function automatic longint atan_k(int i);
		longint t[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149};
		if (i < 10) return t[i];
		return (i >= 31) ? 0 : (64'sd1 << (30 - i));
	endfunction

	task automatic sin_cos(input logic [13:0] p, output longint co, output longint si);
		longint x, y, z, t;
		logic [1:0] q;
		q = p[13:12];
		z = (longint'(p[11:0]) * 64'sd1686629713) >>> 12;
		x = 64'sd652032874;
		y = 0;
		for (int i = 0; i < CORDIC_N && i < 32; i++) begin
			if (z >= 0) begin
				t = x - asr(y, i); y = y + asr(x, i); z -= atan_k(i);
			end else begin
				t = x + asr(y, i); y = y - asr(x, i); z += atan_k(i);
			end
			x = t;
		end
		case (q)
			2'd0: begin co = x; si = y; end
			2'd1: begin co = -y; si = x; end
			2'd2: begin co = -x; si = -y; end
			default: begin co = y; si = -x; end
		endcase
	endtask

	function automatic longint vec_angle(longint y, longint x);
		longint z, m, ax, ay, t;
		z = 0;
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		m = ax > ay ? ax : ay;
		if (m == 0) return 0;
		while (m < (64'sd1 << 40)) begin x *= 2; y *= 2; m *= 2; end
		if (x < 0) begin
			z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
			x = -x; y = -y;
		end
		for (int i = 0; i < CORDIC_N && i < 32; i++) begin
			if (y >= 0) begin
				t = x + asr(y, i); y = y - asr(x, i); z += atan_k(i);
			end else begin
				t = x - asr(y, i); y = y + asr(x, i); z -= atan_k(i);
			end
			x = t;
		end
		return z;
	endfunction

	task automatic contact_pt(input logic signed [15:0] steer, input logic signed [15:0] tk,
		input longint unsigned g, input longint bx, input longint by,
		output longint px, output longint py);
		longint travel, co, si;
		travel = rnd_sh(longint'(tk) * longint'(mpt) * longint'(g), 16);
		sin_cos(steer[13:0], co, si);
		co = rnd_sh(co, 10);
		si = rnd_sh(si, 10);
		px = bx + rnd_sh(co * travel, 20);
		py = by + rnd_sh(si * travel, 20);
	endtask

	task automatic predict_pose(input frame_t f);
		longint sc, half, ax, ay, bx, by, cx, cy, fx, fy;
		int sx, sy, st;
		pose_t p;
		sc = longint'((spacing * 64'd1859775393 + (64'd3 << 26)) / (64'd6 << 26));
		half = longint'(spacing << 3);
		contact_pt(f.fl_steer, f.fl_ticks, gain_fl, sc, -half, ax, ay);
		contact_pt(f.fr_steer, f.fr_ticks, gain_fr, sc, half, bx, by);
		contact_pt(f.r_steer, f.r_ticks, gain_r, -2 * sc, 0, cx, cy);
		sx = sat(floor48(ax + bx + cx + 24));
		sy = sat(floor48(-(ay + by + cy) + 24));
		fx = ax + bx - 2 * cx;
		fy = ay + by - 2 * cy;
		st = int'(-rnd_sh(vec_angle(fy, fx), 14));
		acc_x = sat(longint'(acc_x) + sx);
		acc_y = sat(longint'(acc_y) + sy);
		acc_hd = sat(longint'(acc_hd) + st);
		p = '{acc_x, acc_y, acc_hd, sx, sy, st};
		pose_q = {pose_q, p};
	endtask

	// one write, then wr_en low before returning, so back-to-back writes never collide
	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input longint unsigned v);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= v[CFG_W-1:0];
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_MPT:   mpt = v & 64'hFFFFFF;
			REG_FLG:   gain_fl = v & 64'hFFFF;
			REG_FRG:   gain_fr = v & 64'hFFFF;
			REG_RG:    gain_r = v & 64'hFFFF;
			REG_SPACE: spacing = v & 64'h1FFFF;
			default: ;
		endcase
		n_cfg++;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (pose_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
	endtask

	// valid stays up after an accept until the next frame or an idle stretch
	task automatic send_frame(input frame_t f);
		if (!no_idle && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		{in_ch.front_left_steer, in_ch.front_left_ticks, in_ch.front_right_steer,
			in_ch.front_right_ticks, in_ch.rear_steer, in_ch.rear_ticks} <= f;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		predict_pose(f);
		n_sent++;
	endtask

	function automatic logic signed [15:0] rnd16();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'(signed'($urandom_range(0, 400)) - 200);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic frame_t rnd_frame();
		frame_t f;
		f = '{rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), rnd16()};
		// mostly plausible driving: small, nearly equal tick counts
		if ($urandom_range(0, 2) != 0) begin
			f.fl_ticks = 16'(signed'($urandom_range(0, 200)) - 100);
			f.fr_ticks = f.fl_ticks + 16'(signed'($urandom_range(0, 6)) - 3);
			f.r_ticks = f.fl_ticks + 16'(signed'($urandom_range(0, 6)) - 3);
		end
		return f;
	endfunction

	// output side: random stall, compare against oldest prediction
	always @(posedge clk) begin
		pose_t got, want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				got = '{out_ch.pose_x, out_ch.pose_y, out_ch.pose_heading,
					out_ch.step_x, out_ch.step_y, out_ch.step_turn};
				if (pose_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected item %h", got);
				end else begin
					want = pose_q.pop_front();
					n_checked++;
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display("mismatch item %0d: exp x%0d y%0d h%0d sx%0d sy%0d st%0d  got x%0d y%0d h%0d sx%0d sy%0d st%0d",
								n_checked, want.pose_x, want.pose_y, want.pose_heading,
								want.step_x, want.step_y, want.step_turn, got.pose_x,
								got.pose_y, got.pose_heading, got.step_x, got.step_y,
								got.step_turn);
					end
				end
			end
		end
	end

	int stall_left = 0;
	always @(posedge clk) begin
		if (!no_idle && stall_left == 0 && $urandom_range(0, 5) == 0)
			stall_left <= $urandom_range(1, 7);
		else if (stall_left > 0)
			stall_left <= stall_left - 1;
		out_ch.ready <= no_idle || stall_left <= 1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYC) begin
			$display("timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic check_row(input row_t r);
		pose_t w;
		send_frame(r.fr);
		if (r.has_exp) begin
			w = pose_q[$];
			if (w.step_x !== r.ex_sx || w.step_y !== r.ex_sy || w.step_turn !== r.ex_st) begin
				errors++;
				if (errors <= 10) $display("table row disagrees with predictor");
			end
		end
	endtask

	initial begin
		row_t r;
		in_ch.valid = 1'b0;
		{in_ch.front_left_steer, in_ch.front_left_ticks, in_ch.front_right_steer,
			in_ch.front_right_ticks, in_ch.rear_steer, in_ch.rear_ticks} = '0;
		mpt = 27012; gain_fl = 4211; gain_fr = 4211; gain_r = 4710; spacing = 29950;
		acc_x = 0; acc_y = 0; acc_hd = 0;

		// zero ticks: points sit on mounts, forward vector on +x
		foreach (rows[i]) rows[i] = '{'0, 1'b0, 0, 0, 0};
		rows[1].fr = '{16'sd0, 16'sd100, 16'sd0, 16'sd100, 16'sd0, 16'sd100};
		rows[2].fr = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
		rows[3].fr = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
		rows[4].fr = '{16'sd4096, 16'sd50, 16'sd4096, 16'sd50, 16'sd4096, 16'sd50};
		rows[5].fr = '{16'sd8192, 16'sd50, 16'sd8192, 16'sd50, 16'sd8192, 16'sd50};
		rows[6].fr = '{16'sd12288, 16'sd50, 16'sd12288, 16'sd50, 16'sd12288, 16'sd50};
		rows[7].fr = '{16'sd0, 16'sd30, 16'sd0, -16'sd30, 16'sd4096, 16'sd30};
		rows[8].fr = '{16'sd100, 16'sd0, 16'sd0, 16'sd0, -16'sd1, 16'sd0};
		rows[9].fr = '{16'sd0, -16'sd32768, 16'sd0, -16'sd32768, 16'sd0, 16'sd32767};
		rows[10].fr = '{-16'sd1, 16'sd1, 16'sd16383, -16'sd1, 16'sd16384, 16'sd1};
		rows[11].fr = '{16'sd2048, 16'sd200, -16'sd2048, 16'sd200, 16'sd0, 16'sd0};
		for (int i = 12; i < N_DIRECTED; i++) rows[i].fr = rnd_frame();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) check_row(rows[i]);
		wait_idle();

		// zero spacing with zero ticks: zero forward vector, turn is zero
		reg_write(REG_SPACE, 0);
		r = '{'0, 1'b1, 0, 0, 0};
		check_row(r);
		// rear pushed ahead of the front pair: forward vector on negative x
		r.fr = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1000};
		r.has_exp = 1'b0;
		check_row(r);
		wait_idle();

		// huge steps and pose saturation
		reg_write(REG_MPT, 24'hFFFFFF);
		reg_write(REG_FLG, 16'hFFFF);
		reg_write(REG_FRG, 16'hFFFF);
		reg_write(REG_RG, 16'hFFFF);
		reg_write(REG_SPACE, 17'h1FFFF);
		reg_write(REG_NONE, 24'h123456);
		for (int i = 0; i < 12; i++) send_frame('{16'sd0, 16'sh7fff, 16'sd0, 16'sh7fff,
			16'sd0, 16'sh7fff});
		for (int i = 0; i < 12; i++) send_frame('{16'sd8192, 16'sh7fff, 16'sd8192,
			16'sh7fff, 16'sd4096, 16'sh7fff});
		wait_idle();

		for (int ph = 0; ph < 4; ph++) begin
			if (ph == 0) begin
				reg_write(REG_MPT, 0); reg_write(REG_FLG, 0);
				reg_write(REG_FRG, 0); reg_write(REG_RG, 0);
			end else begin
				reg_write(REG_MPT, $urandom_range(0, 24'hFFFFFF));
				reg_write(REG_FLG, $urandom_range(0, 16'hFFFF));
				reg_write(REG_FRG, $urandom_range(0, 16'hFFFF));
				reg_write(REG_RG, $urandom_range(0, 16'hFFFF));
				reg_write(REG_SPACE, $urandom_range(0, 17'h1FFFF));
			end
			if (ph == 3) begin
				reg_write(REG_MPT, 27012); reg_write(REG_FLG, 4211);
				reg_write(REG_FRG, 4211); reg_write(REG_RG, 4710);
				reg_write(REG_SPACE, 29950);
			end
			for (int i = 0; i < N_RANDOM / 4; i++) begin
				if (ph == 3 && i > N_RANDOM / 8) no_idle = 1;
				send_frame(rnd_frame());
			end
			wait_idle();
		end

		$display("frames sent %0d, results checked %0d, register writes %0d",
			n_sent, n_checked, n_cfg);
		$display("covered steer quadrants, tick extremes, saturation and degenerate turns");
		if (errors == 0 && pose_q.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("failures: %0d, left over: %0d", errors, pose_q.size());
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
